// File: rtl/rq_pkg.sv
// ----------------------------------------------------------------------------
// rq_pkg
// Shared types and defaults for the ready queue with removal by key.
// ----------------------------------------------------------------------------
package rq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  typedef enum logic [1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_DEQUEUE  = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_REMOVE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] process_id;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] result_id;
    logic [4:0]  entry_count;
    logic [15:0] head_id;
    logic        head_valid;
  } rsp_t;

endpackage

// File: rtl/rq_ram.sv
// ----------------------------------------------------------------------------
// rq_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rq_engine.sv
// ----------------------------------------------------------------------------
// rq_engine
// Sequencer for the queue: one compare unit walks the entry RAM for search,
// and the same read/write pipeline closes the gap after a removal or a dequeue.
// ----------------------------------------------------------------------------
module rq_engine import rq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  cmd_t                           cmd,
  output logic                           res_valid,
  output rsp_t                           res,
  input  logic                           res_take,
  output logic                           ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
  output logic [ID_BITS-1:0]             ram_wdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
  input  logic [ID_BITS-1:0]             ram_rdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t          state;
  op_t             op;
  status_t         status;
  logic [15:0]     result_id;
  logic [ID_BITS-1:0] id;
  logic [ID_BITS-1:0] head;
  logic [CW-1:0]   len;
  logic [CW-1:0]   raddr;
  logic [AW-1:0]   didx;
  logic            rvalid;

  logic [ID_BITS-1:0] id_in;
  logic            issue;
  logic            last;
  logic            hit;

  assign id_in = ID_BITS'(cmd.process_id);
  assign issue = raddr < len;
  // data now on the read port belongs to the last valid entry
  assign last  = (CW'(didx) + CW'(1)) == len;
  assign hit   = ram_rdata == id;

  assign cmd_stall = state != S_IDLE;
  assign ram_raddr = raddr[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = len[AW-1:0];
    ram_wdata = id_in;
    if (state == S_IDLE && cmd_valid && cmd.opcode == OP_ENQUEUE &&
        len != CW'(QUEUE_DEPTH)) begin
      ram_we = 1'b1;
    end else if (state == S_SHIFT && rvalid) begin
      ram_we    = 1'b1;
      ram_waddr = didx - AW'(1);
      ram_wdata = ram_rdata;
    end
  end

  assign res_valid        = state == S_DONE;
  assign res.status       = status;
  assign res.result_id    = result_id;
  assign res.entry_count  = 5'(len);
  assign res.head_valid   = len != '0;
  assign res.head_id      = (len != '0) ? 16'(head) : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      len    <= '0;
      rvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rvalid <= 1'b0;
          if (cmd_valid) begin
            id        <= id_in;
            op        <= cmd.opcode;
            result_id <= 16'd0;
            status    <= ST_OK;
            case (cmd.opcode)
              OP_ENQUEUE: begin
                if (len == CW'(QUEUE_DEPTH)) begin
                  status <= ST_FULL;
                end else begin
                  len <= len + CW'(1);
                  if (len == '0) begin
                    head <= id_in;
                  end
                end
                state <= S_DONE;
              end
              OP_DEQUEUE: begin
                if (len == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_DONE;
                end else begin
                  result_id <= 16'(head);
                  if (len == CW'(1)) begin
                    len   <= '0;
                    state <= S_DONE;
                  end else begin
                    raddr <= CW'(1);
                    state <= S_SHIFT;
                  end
                end
              end
              default: begin
                if (len == '0) begin
                  status <= ST_NOT_FOUND;
                  state  <= S_DONE;
                end else begin
                  raddr <= '0;
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          rvalid <= issue;
          if (issue) begin
            raddr <= raddr + CW'(1);
            didx  <= raddr[AW-1:0];
          end
          if (rvalid) begin
            if (hit) begin
              if (op == OP_CONTAINS) begin
                state <= S_DONE;
              end else if (last) begin
                len   <= len - CW'(1);
                state <= S_DONE;
              end else begin
                // read of the next entry is already in flight
                state <= S_SHIFT;
              end
            end else if (last) begin
              status <= ST_NOT_FOUND;
              state  <= S_DONE;
            end
          end
        end
        S_SHIFT: begin
          rvalid <= issue;
          if (issue) begin
            raddr <= raddr + CW'(1);
            didx  <= raddr[AW-1:0];
          end
          if (rvalid) begin
            if (didx == AW'(1)) begin
              head <= ram_rdata;
            end
            if (last) begin
              len   <= len - CW'(1);
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_shift_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && ram_we) |-> (CW'(ram_waddr) + CW'(1)) < len)
    else $error("gap close writes beyond the valid entries");

  a_read_pipe_aligned: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN || state == S_SHIFT) && rvalid) |->
      raddr == (CW'(didx) + CW'(1)))
    else $error("read pipeline out of step with data index");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res_take) |=> (state == S_DONE && $stable(res)))
    else $error("pending result lost before transfer");

endmodule

// File: rtl/ready_queue_with_removal.sv
// ----------------------------------------------------------------------------
// ready_queue_with_removal
// Ordered queue of process identifiers with enqueue, dequeue, search and
// removal of the first matching entry.
// ----------------------------------------------------------------------------
// One command is taken at a time; cmd_stall is high from acceptance until its
// result is handed to the output register, which holds it while rsp_stall is
// high and does not block the next command. An enqueue, a dequeue that finds
// the queue empty or leaves it empty, and any operation on an empty queue go
// straight to the result. A contains query walks the entries from the head
// (position 0) and stops at the first match; one that finds nothing walks all
// of them. A removal walks every entry whether or not it finds a match, and
// a dequeue from a queue of two or more entries moves every entry after the
// head down by one. A result waits in the engine while the output register
// is full and rsp_stall is high. The search and the gap closing walk the
// entry RAM through its single read port, one entry per cycle. The entries
// need no clearing after reset, since only entries below the count are ever
// read.
module ready_queue_with_removal import rq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic               res_valid;
  rsp_t               res;
  logic               res_take;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ID_BITS-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ID_BITS-1:0] ram_rdata;

  rq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output slot is free when empty or being transferred this cycle
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule
